/* sv/fte_pkg.sv */
// ----------------------------------------------------------------------------
// FAT12 table engine package
// Shared types, codes and helper functions for the packed 12-bit table engine.
// ----------------------------------------------------------------------------
package fte_pkg;

  // Default table size in entries and the reset value of the scan limit.
  localparam int unsigned DEF_TABLE_ENTRIES = 4096;
  localparam logic [11:0] SCAN_LIMIT_RST    = 12'd2847;

  // Entry values with a fixed meaning.
  localparam logic [11:0] EOC_MIN       = 12'hFF0;
  localparam logic [11:0] FREE_MARK     = 12'h000;
  localparam logic [11:0] FIRST_CLUSTER = 12'd2;

  // Nibble masks for the shared byte between two entries.
  localparam logic [7:0] NIB_LO = 8'h0F;
  localparam logic [7:0] NIB_HI = 8'hF0;

  // Operation codes carried by the op field.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FIND  = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic load_in;
    logic rd_en;
    logic mem_we;
    logic cnt_inc;
    logic cur_step;
    logic hit_set;
    logic out_load;
  } fte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic clr_last;
    logic idx_ok;
    logic scan_empty;
    logic is_zero;
    logic hit;
    logic at_top;
  } fte_status_t;

  // Assemble an entry from the two bytes it spans.
  function automatic logic [11:0] entry_decode(input logic [7:0] b0,
                                               input logic [7:0] b1,
                                               input logic       odd);
    logic [11:0] v;
    if (odd) begin
      v = {b1, b0[7:4]};
    end else begin
      v = {b1[3:0], b0};
    end
    return v;
  endfunction

  // Merge a new entry value into its two bytes, keeping the neighbor's nibble.
  // Returns {byte1, byte0}.
  function automatic logic [15:0] entry_merge(input logic [7:0]  b0,
                                              input logic [7:0]  b1,
                                              input logic        odd,
                                              input logic [11:0] v);
    logic [7:0] n0;
    logic [7:0] n1;
    if (odd) begin
      n0 = (b0 & NIB_LO) | ({v[3:0], 4'h0} & NIB_HI);
      n1 = v[11:4];
    end else begin
      n0 = v[7:0];
      n1 = (b1 & NIB_HI) | ({4'h0, v[11:8]} & NIB_LO);
    end
    return {n1, n0};
  endfunction

endpackage

/* sv/fat12_table_engine_core.sv */
// ----------------------------------------------------------------------------
// FAT12 table engine core
// Packed 12-bit allocation table with read, write, find-free and count-free.
// ----------------------------------------------------------------------------
// After reset the table store is cleared one row of bytes per cycle, over
// B = (3*TABLE_ENTRIES+1)/2 table bytes. in_stall stays high until the clear
// is done, and scan_limit writes are still taken while it runs. The block then
// handles one beat at a time. A read or write steps through accept, fetch both
// bytes from the two byte banks, evaluate or write back, and present the
// result. A read or write whose index lies beyond the table skips the evaluate
// step. Find-free and count-free walk the table from cluster 2 with one fetch
// and one evaluate step per entry, visiting up to min(scan_limit, 4095)-1
// entries. An empty scan range skips the evaluate step. The result sits in an
// output register, so a stalled result only holds the block in its finish
// state.
module fat12_table_engine_core
  import fte_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [11:0] entry_index,
  input  logic [11:0] new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] result_value,
  output logic        found,
  output logic        end_of_chain
);

  fte_cmd_t    cmd;
  fte_status_t status;

  // Controller.
  fte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath with the byte store.
  fte_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .op           (op),
    .entry_index  (entry_index),
    .new_value    (new_value),
    .cmd          (cmd),
    .status       (status),
    .result_value (result_value),
    .found        (found),
    .end_of_chain (end_of_chain)
  );

endmodule

/* sv/fte_ctrl.sv */
// ----------------------------------------------------------------------------
// FAT12 table engine controller
// Sequences the clearing pass, table accesses and scans, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module fte_ctrl
  import fte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  fte_status_t status,
  output fte_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result slot can take a new beat when empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        unique case (status.op)
          OP_READ, OP_WRITE: begin
            state_next = status.idx_ok ? ST_EVAL : ST_FINISH;
          end
          OP_FIND, OP_COUNT: begin
            state_next = status.scan_empty ? ST_FINISH : ST_EVAL;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_EVAL: begin
        unique case (status.op)
          OP_READ, OP_WRITE: state_next = ST_FINISH;
          OP_FIND: begin
            if (status.hit || status.at_top) begin
              state_next = ST_FINISH;
            end else begin
              state_next = ST_FETCH;
            end
          end
          OP_COUNT: begin
            state_next = status.at_top ? ST_FINISH : ST_FETCH;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      ST_IDLE: begin
        cmd.load_in = in_valid;
      end
      ST_FETCH: begin
        unique case (status.op)
          OP_READ, OP_WRITE: cmd.rd_en = status.idx_ok;
          OP_FIND, OP_COUNT: cmd.rd_en = !status.scan_empty;
          default: cmd.rd_en = 1'b0;
        endcase
      end
      ST_EVAL: begin
        unique case (status.op)
          OP_READ: begin
          end
          OP_WRITE: begin
            cmd.mem_we = 1'b1;
          end
          OP_FIND: begin
            cmd.hit_set  = status.hit;
            cmd.cur_step = !status.hit && !status.at_top;
          end
          OP_COUNT: begin
            cmd.cnt_inc  = status.is_zero;
            cmd.cur_step = !status.at_top;
          end
          default: begin
          end
        endcase
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/fte_datapath.sv */
// ----------------------------------------------------------------------------
// FAT12 table engine datapath
// Packed byte store in two banks (even and odd byte offsets), entry decode
// and merge, scan cursor, free counter, scan limit and the result register.
// ----------------------------------------------------------------------------
module fte_datapath
  import fte_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic [1:0]  op,
  input  logic [11:0] entry_index,
  input  logic [11:0] new_value,
  input  fte_cmd_t    cmd,
  output fte_status_t status,
  output logic [11:0] result_value,
  output logic        found,
  output logic        end_of_chain
);

  // Store geometry: entry n starts at byte n + n/2; two banks give both
  // bytes of an entry from a single read.
  localparam int unsigned TABLE_BYTES = (3 * TABLE_ENTRIES + 1) / 2;
  localparam int unsigned EVEN_DEPTH  = (TABLE_BYTES + 1) / 2;
  localparam int unsigned ODD_DEPTH   = TABLE_BYTES / 2;
  localparam int unsigned EVEN_AW     = $clog2(EVEN_DEPTH);
  localparam int unsigned ODD_AW      = $clog2(ODD_DEPTH);
  localparam int unsigned OFF_W       = $clog2(TABLE_BYTES);
  localparam int unsigned IDX_W       = $clog2(TABLE_ENTRIES);
  localparam logic [12:0] ENTRIES_L   = 13'(TABLE_ENTRIES);
  localparam logic [11:0] LAST_ENTRY  = 12'(TABLE_ENTRIES - 1);

  logic [7:0] mem_even [EVEN_DEPTH];
  logic [7:0] mem_odd  [ODD_DEPTH];

  op_t          op_q;
  logic [11:0]  idx_q;
  logic [11:0]  val_q;
  logic [11:0]  cursor;
  logic [11:0]  count;
  logic         hit_q;
  logic [11:0]  scan_limit;
  logic [EVEN_AW-1:0] clr_cnt;
  logic [7:0]   rd_even;
  logic [7:0]   rd_odd;

  logic [11:0]        acc_idx;
  logic [IDX_W-1:0]   acc_lo;
  logic [OFF_W-1:0]   off;
  logic [OFF_W-1:0]   off_p1;
  logic               odd_off;
  logic [EVEN_AW-1:0] even_addr;
  logic [ODD_AW-1:0]  odd_addr;
  logic [7:0]         b0;
  logic [7:0]         b1;
  logic [11:0]        entry_val;
  logic [11:0]        read_val;
  logic [15:0]        merged;
  logic [11:0]        top_eff;
  logic               idx_ok;
  logic               clr_odd_ok;

  logic               even_we;
  logic [EVEN_AW-1:0] even_wa;
  logic [7:0]         even_wd;
  logic               odd_we;
  logic [ODD_AW-1:0]  odd_wa;
  logic [7:0]         odd_wd;

  // Input beat capture and scan state.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= op_t'(op);
      idx_q <= entry_index;
      val_q <= new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= FIRST_CLUSTER;
      count  <= '0;
      hit_q  <= 1'b0;
    end else if (cmd.load_in) begin
      cursor <= FIRST_CLUSTER;
      count  <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cmd.cur_step) cursor <= cursor + 12'd1;
      if (cmd.cnt_inc)  count  <= count + 12'd1;
      if (cmd.hit_set)  hit_q  <= 1'b1;
    end
  end

  // Scan limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= SCAN_LIMIT_RST;
    end else if (cfg_we) begin
      scan_limit <= cfg_wdata;
    end
  end

  // Clearing pass row counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + EVEN_AW'(1);
    end
  end

  // Address generation for the entry under access.
  always_comb begin
    acc_idx   = ((op_q == OP_FIND) || (op_q == OP_COUNT)) ? cursor : idx_q;
    acc_lo    = acc_idx[IDX_W-1:0];
    off       = OFF_W'(acc_lo) + OFF_W'(acc_lo >> 1);
    off_p1    = off + OFF_W'(1);
    odd_off   = off[0];
    even_addr = EVEN_AW'(off_p1 >> 1);
    odd_addr  = ODD_AW'(off >> 1);
  end

  // Entry decode and merge.
  always_comb begin
    b0        = odd_off ? rd_odd : rd_even;
    b1        = odd_off ? rd_even : rd_odd;
    entry_val = entry_decode(b0, b1, acc_lo[0]);
    merged    = entry_merge(b0, b1, acc_lo[0], val_q);
    idx_ok    = ({1'b0, idx_q} < ENTRIES_L);
    read_val  = idx_ok ? entry_val : FREE_MARK;
    top_eff   = (scan_limit > LAST_ENTRY) ? LAST_ENTRY : scan_limit;
  end

  // Bank write ports: clearing pass or write-back.
  always_comb begin
    clr_odd_ok = ({1'b0, clr_cnt} < (EVEN_AW + 1)'(ODD_DEPTH));
    if (cmd.clr_we) begin
      even_we = 1'b1;
      even_wa = clr_cnt;
      even_wd = 8'h00;
      odd_we  = clr_odd_ok;
      odd_wa  = ODD_AW'(clr_cnt);
      odd_wd  = 8'h00;
    end else begin
      even_we = cmd.mem_we;
      even_wa = even_addr;
      even_wd = odd_off ? merged[15:8] : merged[7:0];
      odd_we  = cmd.mem_we;
      odd_wa  = odd_addr;
      odd_wd  = odd_off ? merged[7:0] : merged[15:8];
    end
  end

  // Even-offset byte bank.
  always_ff @(posedge clk) begin
    if (even_we) mem_even[even_wa] <= even_wd;
    if (cmd.rd_en) rd_even <= mem_even[even_addr];
  end

  // Odd-offset byte bank.
  always_ff @(posedge clk) begin
    if (odd_we) mem_odd[odd_wa] <= odd_wd;
    if (cmd.rd_en) rd_odd <= mem_odd[odd_addr];
  end

  // Status back to the controller.
  always_comb begin
    status.op         = op_q;
    status.clr_last   = (clr_cnt == EVEN_AW'(EVEN_DEPTH - 1));
    status.idx_ok     = idx_ok;
    status.scan_empty = (scan_limit < FIRST_CLUSTER);
    status.is_zero    = (entry_val == FREE_MARK);
    status.hit        = (entry_val == FREE_MARK) && (cursor != idx_q);
    status.at_top     = (cursor == top_eff);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (op_q)
        OP_READ: begin
          result_value <= read_val;
          found        <= 1'b1;
          end_of_chain <= (read_val >= EOC_MIN);
        end
        OP_WRITE: begin
          result_value <= '0;
          found        <= 1'b1;
          end_of_chain <= 1'b0;
        end
        OP_FIND: begin
          result_value <= hit_q ? cursor : '0;
          found        <= hit_q;
          end_of_chain <= 1'b0;
        end
        OP_COUNT: begin
          result_value <= count;
          found        <= 1'b1;
          end_of_chain <= 1'b0;
        end
        default: begin
          result_value <= '0;
          found        <= 1'b1;
          end_of_chain <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* sv/fte_checker.sv */
// ----------------------------------------------------------------------------
// FAT12 table engine checker
// Port-level assertions on the engine, bound to the top level.
// ----------------------------------------------------------------------------
module fte_checker
  import fte_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] result_value,
  input logic        found,
  input logic        end_of_chain
);

  // One beat at a time: an accepted beat blocks the input on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_value)
                                  && $stable(found) && $stable(end_of_chain)))
    else $error("stalled result changed");

  // A failed free search reports index zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (result_value == 12'h000 && !end_of_chain))
    else $error("not-found result carries a value");

  // End of chain is only flagged for values in the reserved top range.
  a_eoc_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_chain) |-> (result_value >= EOC_MIN))
    else $error("end of chain flagged below threshold");

endmodule

bind fat12_table_engine_core fte_checker u_fte_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .found        (found),
  .end_of_chain (end_of_chain)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT12 table engine testbench
// Drives read, write, find-free and count-free beats into the core under
// random idling and output stalls. It checks each result against a local
// model of the packed 12-bit table or a fixed expectation. A directed table
// comes first, then random phases, each with its own scan limit.
// ----------------------------------------------------------------------------
module testbench;
  import fte_pkg::*;

  localparam int unsigned TABLE_ENTRIES  = DEF_TABLE_ENTRIES;
  localparam int unsigned TABLE_BYTES    = (3 * TABLE_ENTRIES + 1) / 2;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned PHASES         = 9;
  localparam int unsigned PHASE_BEATS    = 50;

  // One result beat as the core presents it.
  typedef struct packed {
    logic [11:0] value;
    logic        found;
    logic        eoc;
  } fat_result_t;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_BEAT_FIXED,
    ROW_LIMIT
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    op_t         beat_op;
    logic [11:0] idx;
    logic [11:0] val;
    fat_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [11:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  op         = OP_READ;
  logic [11:0] entry_index = '0;
  logic [11:0] new_value  = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [11:0] result_value;
  logic        found;
  logic        end_of_chain;

  // Local copy of the table, the scan limit and the results still owed.
  logic [7:0]  fat_bytes [TABLE_BYTES];
  logic [11:0] scan_limit_q;
  fat_result_t pending_results [$];
  plan_row_t   plan_q [$];

  int unsigned error_count = 0;
  int unsigned next_gap    = 1;
  logic        calm        = 1'b0;

  fat12_table_engine_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .entry_index  (entry_index),
    .new_value    (new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .found        (found),
    .end_of_chain (end_of_chain)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Read entry n from the byte image; an even entry starts on a whole byte.
  function automatic logic [11:0] image_entry(input int unsigned n);
    int unsigned base;
    if (n >= TABLE_ENTRIES) return 12'h000;
    base = (3 * n) / 2;
    if (n % 2 == 1) return {fat_bytes[base + 1], fat_bytes[base][7:4]};
    return {fat_bytes[base + 1][3:0], fat_bytes[base]};
  endfunction

  // Store entry n, leaving the nibble that belongs to the neighbor alone.
  function automatic void fat_store(input int unsigned n, input logic [11:0] v);
    int unsigned base;
    if (n >= TABLE_ENTRIES) return;
    base = (3 * n) / 2;
    if (n % 2 == 1) begin
      fat_bytes[base][7:4] = v[3:0];
      fat_bytes[base + 1]  = v[11:4];
    end else begin
      fat_bytes[base]          = v[7:0];
      fat_bytes[base + 1][3:0] = v[11:8];
    end
  endfunction

  // Apply one beat to the table image and return the result it should cause.
  function automatic fat_result_t fat_predict(input op_t kind, input logic [11:0] idx,
                                              input logic [11:0] val);
    fat_result_t r;
    int unsigned top;
    int unsigned i;
    r.value = 12'h000;
    r.found = 1'b1;
    r.eoc   = 1'b0;
    top = (scan_limit_q > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1 : scan_limit_q;
    case (kind)
      OP_READ: begin
        r.value = image_entry(idx);
        r.eoc   = (r.value >= EOC_MIN);
      end
      OP_WRITE: begin
        fat_store(idx, val);
      end
      OP_FIND: begin
        r.found = 1'b0;
        for (i = FIRST_CLUSTER; i <= top && !r.found; i++) begin
          if (image_entry(i) == FREE_MARK && i != idx) begin
            r.value = i[11:0];
            r.found = 1'b1;
          end
        end
      end
      default: begin
        for (i = FIRST_CLUSTER; i <= top; i++) begin
          if (image_entry(i) == FREE_MARK) r.value = r.value + 12'd1;
        end
      end
    endcase
    return r;
  endfunction

  // Half the time no gap, otherwise mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void plan_add(input row_kind_t k, input op_t o, input logic [11:0] idx,
                                   input logic [11:0] val, input logic [11:0] rv,
                                   input logic rf, input logic re);
    plan_row_t row;
    row.kind       = k;
    row.beat_op    = o;
    row.idx        = idx;
    row.val        = val;
    row.want.value = rv;
    row.want.found = rf;
    row.want.eoc   = re;
    plan_q.push_back(row);
  endfunction

  // Present one beat and record its expected result once it is taken.
  task automatic drive_beat(input op_t kind, input logic [11:0] idx, input logic [11:0] val,
                            input logic fixed, input fat_result_t want);
    fat_result_t r;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_valid    <= 1'b1;
    op          <= kind;
    entry_index <= idx;
    new_value   <= val;
    do @(posedge clk); while (in_stall);
    r = fat_predict(kind, idx, val);
    pending_results.push_back(fixed ? want : r);
    next_gap = pick_gap();
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  // Drop valid if the next beat was going to follow back to back.
  task automatic end_burst();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
  endtask

  // The limit is only written once the core has handed back every result.
  task automatic set_scan_limit(input logic [11:0] v);
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scan_limit_q = v;
  endtask

  // Result side: check each accepted beat, then choose the next stall.
  always @(posedge clk) begin : result_side
    int unsigned stall_run;
    int unsigned roll;
    fat_result_t got;
    fat_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.value = result_value;
      got.found = found;
      got.eoc   = end_of_chain;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat: value %03h found %0d eoc %0d",
                   got.value, got.found, got.eoc);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected value %03h found %0d eoc %0d, got %03h %0d %0d",
                     want.value, want.found, want.eoc, got.value, got.found, got.eoc);
        end
      end
    end
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) stall_run = $urandom_range(1, 3);
        else if (roll < 23) stall_run = $urandom_range(15, 60);
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned phase;
    int unsigned beat;
    int unsigned roll;
    int unsigned region;
    logic [11:0] lim;
    logic [11:0] idx;
    logic [11:0] val;
    logic        big;
    op_t         kind;
    fat_result_t none;
    plan_row_t   row;

    none = '0;
    for (i = 0; i < TABLE_BYTES; i++) fat_bytes[i] = 8'h00;
    scan_limit_q = SCAN_LIMIT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: kind, op, index, value, then the expected result where fixed.
    plan_add(ROW_BEAT_FIXED, OP_READ,  12'd0,    12'h000, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_READ,  12'd4095, 12'h000, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_WRITE, 12'd4095, 12'hFFF, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_READ,  12'd4095, 12'h000, 12'hFFF, 1'b1, 1'b1);
    plan_add(ROW_BEAT_FIXED, OP_WRITE, 12'd4094, 12'hFF0, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_READ,  12'd4094, 12'h000, 12'hFF0, 1'b1, 1'b1);
    plan_add(ROW_BEAT_FIXED, OP_WRITE, 12'd4093, 12'hFEF, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_READ,  12'd4093, 12'h000, 12'hFEF, 1'b1, 1'b0);
    plan_add(ROW_BEAT,       OP_WRITE, 12'd2,    12'hABC, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_WRITE, 12'd3,    12'h123, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_READ,  12'd2,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_READ,  12'd3,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_WRITE, 12'd4,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_FIND,  12'd4,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_COUNT, 12'd0,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_LIMIT,      OP_READ,  12'd0,    12'd2,   12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_FIND,  12'd0,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_COUNT, 12'd0,    12'h000, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_LIMIT,      OP_READ,  12'd0,    12'd0,   12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_FIND,  12'd0,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_COUNT, 12'd0,    12'h000, 12'h000, 1'b1, 1'b0);
    plan_add(ROW_LIMIT,      OP_READ,  12'd0,    12'd1,   12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT_FIXED, OP_FIND,  12'd2,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_LIMIT,      OP_READ,  12'd0,    12'd4095, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_WRITE, 12'd2,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_FIND,  12'd2,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_COUNT, 12'd0,    12'h000, 12'h000, 1'b0, 1'b0);
    plan_add(ROW_BEAT,       OP_READ,  12'd4094, 12'h000, 12'h000, 1'b0, 1'b0);

    foreach (plan_q[n]) begin
      row = plan_q[n];
      if (row.kind == ROW_LIMIT) set_scan_limit(row.val);
      else drive_beat(row.beat_op, row.idx, row.val, row.kind == ROW_BEAT_FIXED, row.want);
    end

    // Random phases. Writes cluster inside the scan range so that find-free
    // has to walk past allocated entries, and a few land anywhere in the table.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: lim = 12'($urandom_range(3, 64));
        1: lim = 12'd4095;
        2: lim = 12'd1;
        3: lim = 12'($urandom_range(2, 16));
        4: lim = 12'($urandom_range(3, 64));
        5: lim = 12'($urandom_range(0, 4095));
        6: lim = 12'd2;
        7: lim = 12'($urandom_range(16, 100));
        default: lim = 12'd0;
      endcase
      set_scan_limit(lim);
      calm   = (phase % 3 == 2);
      big    = (lim > 12'd200);
      region = big ? 120 : lim + 4;
      for (beat = 0; beat < PHASE_BEATS; beat++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) kind = OP_WRITE;
        else if (roll < 70) kind = OP_READ;
        else if (roll < (big ? 98 : 90)) kind = OP_FIND;
        else kind = OP_COUNT;
        if ($urandom_range(0, 9) == 0) idx = 12'($urandom_range(0, 4095));
        else idx = 12'($urandom_range(0, region));
        roll = $urandom_range(0, 99);
        if (roll < 25) val = FREE_MARK;
        else if (roll < 40) val = 12'($urandom_range(EOC_MIN, 4095));
        else val = 12'($urandom_range(1, 4095));
        drive_beat(kind, idx, val, 1'b0, none);
      end
    end

    // Drain and let the core settle before the verdict.
    end_burst();
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fte_pkg.sv
sv/fte_ctrl.sv
sv/fte_datapath.sv
sv/fat12_table_engine_core.sv
sv/fte_checker.sv
sim/testbench.sv
